### src/assert_macros.svh
// Assertion macros used by the RTL of the point density histogram.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### src/pdh_pkg.sv
// Package for the point density histogram: sizes, operation and register codes,
// sequencer states. No dependencies.
package pdh_pkg;

  // Store geometry and counter sizes
  localparam int MAX_GRID_WIDTH  = 512;
  localparam int MAX_GRID_HEIGHT = 512;
  localparam int COUNT_BITS      = 32;
  localparam int STORE_DEPTH     = MAX_GRID_WIDTH * MAX_GRID_HEIGHT;
  localparam int ADDR_W          = $clog2(STORE_DEPTH);
  localparam int COL_W           = $clog2(MAX_GRID_WIDTH);
  localparam int ROW_W           = $clog2(MAX_GRID_HEIGHT);

  // Fixed field widths
  localparam int COORD_W = 16;
  localparam int GRID_W  = 10;
  localparam int BIN_W   = 18;
  localparam int CNT_W   = 32;
  localparam int ITER_W  = 48;

  // Datapath widths: rotated coordinate, offset sum, scaled value
  localparam int RX_W     = 19;
  localparam int XS_W     = 21;
  localparam int V_W      = 38;
  localparam int V_SHIFT  = 21;
  localparam int CU_W     = V_W - V_SHIFT;

  typedef enum logic [1:0] {
    OP_PLOT        = 2'd0,
    OP_READ        = 2'd1,
    OP_CLEAR       = 2'd2,
    OP_RESET_STATS = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_ROTATE_ENABLE = 3'd0,
    REG_COS_ROTATION  = 3'd1,
    REG_SIN_ROTATION  = 3'd2,
    REG_X_OFFSET      = 3'd3,
    REG_Y_OFFSET      = 3'd4,
    REG_VIEW_SCALE    = 3'd5,
    REG_GRID_WIDTH    = 3'd6,
    REG_GRID_HEIGHT   = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ROT1,
    S_ROT2,
    S_ROT3,
    S_SUM,
    S_SCALE,
    S_BIN,
    S_IDX,
    S_READ,
    S_DONE
  } state_t;

endpackage

### src/point_density_histogram_core.sv
// Point density histogram core: plot, read, clear and statistics reset on a
// bin store held in one synchronous RAM. Depends on pdh_pkg, assert_macros.svh.
//
//  channel | role                 | handshake
//  --------+----------------------+----------------------------------------
//  in_     | operation and point  | tvalid/tready, operation in tuser
//  out_    | one result per item  | tvalid/tready, in_range in tuser
//  cfg_    | register file        | APB write/read, pready tied high
//
// One item is in flight at a time. A plot with rotation steps through ROT1,
// ROT2, ROT3, SUM, SCALE, BIN, IDX, READ and DONE; without rotation it starts
// at SUM, and a clipped plot goes from BIN straight to DONE. A read or clear
// passes READ and DONE (only DONE if out of range), a statistics reset DONE.
// After reset a clearing pass writes zero to every bin, all STORE_DEPTH
// (262144) of them, with in_tready low; configuration writes are taken meanwhile.
// The result sits in an output register: a stalled result blocks the next
// result only, and the block holds in its final step until the register frees.
module point_density_histogram_core (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [87:0]               in_tdata,   // point_x, point_y, blur_x, blur_y, bin_select
  input  logic [1:0]                in_tuser,   // operation
  // result channel
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [135:0]              out_tdata,  // bin_index, bin_count, max_count, iteration_total
  output logic [0:0]                out_tuser,  // in_range
  // configuration port
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [4:0]                cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);
  import pdh_pkg::*;
  `include "assert_macros.svh"

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic signed [V_W-1:0] NEG_LIMIT = -(V_W'(64'sd1 <<< V_SHIFT));

  // ---------------------------------------------------------------- config
  logic                      rot_en_r;
  logic [COORD_W-1:0]        cos_r, sin_r, xoff_r, yoff_r, scale_r;
  logic [GRID_W-1:0]         gw_r, gh_r;
  logic                      cfg_wr;
  reg_idx_t                  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_en_r <= 1'b0;
      cos_r    <= 16'd16384;
      sin_r    <= '0;
      xoff_r   <= '0;
      yoff_r   <= '0;
      scale_r  <= 16'd26214;
      gw_r     <= 10'd512;
      gh_r     <= 10'd512;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ROTATE_ENABLE: rot_en_r <= cfg_pwdata[0];
        REG_COS_ROTATION:  cos_r    <= cfg_pwdata[15:0];
        REG_SIN_ROTATION:  sin_r    <= cfg_pwdata[15:0];
        REG_X_OFFSET:      xoff_r   <= cfg_pwdata[15:0];
        REG_Y_OFFSET:      yoff_r   <= cfg_pwdata[15:0];
        REG_VIEW_SCALE:    scale_r  <= cfg_pwdata[15:0];
        REG_GRID_WIDTH:    gw_r     <= cfg_pwdata[GRID_W-1:0];
        REG_GRID_HEIGHT:   gh_r     <= cfg_pwdata[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      REG_ROTATE_ENABLE: cfg_prdata = {31'd0, rot_en_r};
      REG_COS_ROTATION:  cfg_prdata = {16'd0, cos_r};
      REG_SIN_ROTATION:  cfg_prdata = {16'd0, sin_r};
      REG_X_OFFSET:      cfg_prdata = {16'd0, xoff_r};
      REG_Y_OFFSET:      cfg_prdata = {16'd0, yoff_r};
      REG_VIEW_SCALE:    cfg_prdata = {16'd0, scale_r};
      REG_GRID_WIDTH:    cfg_prdata = 32'(gw_r);
      REG_GRID_HEIGHT:   cfg_prdata = 32'(gh_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // grid size clamped to the store
  logic [GRID_W-1:0] w_eff, h_eff;
  assign w_eff = (32'(gw_r) > MAX_GRID_WIDTH)  ? GRID_W'(MAX_GRID_WIDTH)  : gw_r;
  assign h_eff = (32'(gh_r) > MAX_GRID_HEIGHT) ? GRID_W'(MAX_GRID_HEIGHT) : gh_r;

  // ---------------------------------------------------------------- input fields
  logic signed [COORD_W-1:0] in_px, in_py, in_bx, in_by;
  logic [BIN_W-1:0]          in_sel;
  op_t                       in_op;
  logic                      in_sel_ok;

  assign in_px     = in_tdata[15:0];
  assign in_py     = in_tdata[31:16];
  assign in_bx     = in_tdata[47:32];
  assign in_by     = in_tdata[63:48];
  assign in_sel    = in_tdata[81:64];
  assign in_op     = op_t'(in_tuser[1:0]);
  assign in_sel_ok = 32'(in_sel) < 32'(STORE_DEPTH);

  // ---------------------------------------------------------------- sequencer
  state_t state_r, state_nxt;
  logic   in_acc;
  logic   out_load;
  logic   out_valid_r;
  logic   clr_last;
  logic   bin_hit;
  op_t    op_r;
  logic   hit_r;
  logic [ADDR_W-1:0] clr_addr_r;

  assign in_acc   = in_tvalid && in_tready;
  assign clr_last = clr_addr_r == ADDR_W'(STORE_DEPTH - 1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_op)
            OP_PLOT:  state_nxt = rot_en_r ? S_ROT1 : S_SUM;
            OP_READ,
            OP_CLEAR: state_nxt = in_sel_ok ? S_READ : S_DONE;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_ROT1:  state_nxt = S_ROT2;
      S_ROT2:  state_nxt = S_ROT3;
      S_ROT3:  state_nxt = S_SUM;
      S_SUM:   state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_BIN;
      S_BIN:   state_nxt = bin_hit ? S_IDX : S_DONE;
      S_IDX:   state_nxt = S_READ;
      S_READ:  state_nxt = S_DONE;
      S_DONE:  if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  logic                  item_wr;
  logic [COUNT_BITS-1:0] item_wdata;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_wa;
  logic [COUNT_BITS-1:0] mem_wd;
  logic [ADDR_W-1:0]     addr_r;

  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = addr_r;
    mem_wd    = item_wdata;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr_r;
        mem_wd = '0;
      end
      S_IDLE: in_tready = 1'b1;
      S_DONE: begin
        out_load = !out_valid_r || out_tready;
        mem_we   = out_load && item_wr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // ---------------------------------------------------------------- datapath
  logic signed [COORD_W-1:0] px_r, py_r, bx_r, by_r;
  logic [BIN_W-1:0]          sel_r;
  logic signed [31:0]        prod_a_r, prod_b_r, mul_a, mul_b;
  logic signed [32:0]        rsum, rdiff;
  logic signed [RX_W-1:0]    rx_r, ry_r;
  logic signed [XS_W-1:0]    xs_r, ys_r;
  logic signed [V_W-1:0]     prodx_r, prody_r, vx, vy;
  logic [CU_W-1:0]           col_u, row_u;
  logic                      col_ok, row_ok;
  logic [COL_W-1:0]          col_r;
  logic [ROW_W-1:0]          row_r;
  logic [GRID_W+ROW_W-1:0]   row_base;

  // rotation products: first step x terms, second step y terms
  assign mul_a = $signed(cos_r) * ((state_r == S_ROT1) ? px_r : py_r);
  assign mul_b = $signed(sin_r) * ((state_r == S_ROT1) ? py_r : px_r);
  assign rsum  = 33'(prod_a_r) + 33'(prod_b_r);
  assign rdiff = 33'(prod_a_r) - 33'(prod_b_r);

  // grid mapping: add center, truncate toward zero, clip
  assign vx     = prodx_r + $signed(V_W'({w_eff, 20'd0}));
  assign vy     = prody_r + $signed(V_W'({h_eff, 20'd0}));
  assign col_u  = vx[V_W-1] ? '0 : vx[V_W-1:V_SHIFT];
  assign row_u  = vy[V_W-1] ? '0 : vy[V_W-1:V_SHIFT];
  assign col_ok = (vx > NEG_LIMIT) && (col_u < CU_W'(w_eff));
  assign row_ok = (vy > NEG_LIMIT) && (row_u < CU_W'(h_eff));
  assign bin_hit = col_ok && row_ok;
  assign row_base = w_eff * row_r;

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_r   <= in_op;
          px_r   <= in_px;
          py_r   <= in_py;
          bx_r   <= in_bx;
          by_r   <= in_by;
          sel_r  <= in_sel;
          rx_r   <= RX_W'(in_px);
          ry_r   <= RX_W'(in_py);
          addr_r <= ADDR_W'(in_sel);
          hit_r  <= (in_op == OP_READ || in_op == OP_CLEAR) ? in_sel_ok : 1'b1;
        end
      end
      S_ROT1: begin
        prod_a_r <= mul_a;
        prod_b_r <= mul_b;
      end
      S_ROT2: begin
        rx_r     <= rsum[32:14];
        prod_a_r <= mul_a;
        prod_b_r <= mul_b;
      end
      S_ROT3: ry_r <= rdiff[32:14];
      S_SUM: begin
        xs_r <= XS_W'(rx_r) + XS_W'(bx_r) + XS_W'($signed(xoff_r));
        ys_r <= XS_W'(ry_r) + XS_W'(by_r) + XS_W'($signed(yoff_r));
      end
      S_SCALE: begin
        prodx_r <= xs_r * $signed({1'b0, scale_r});
        prody_r <= ys_r * $signed({1'b0, scale_r});
      end
      S_BIN: begin
        hit_r <= bin_hit;
        col_r <= COL_W'(col_u);
        row_r <= ROW_W'(row_u);
      end
      S_IDX: addr_r <= ADDR_W'(col_r) + ADDR_W'(row_base);
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- bin store
  logic [COUNT_BITS-1:0] hist_mem [STORE_DEPTH];
  logic [COUNT_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) hist_mem[mem_wa] <= mem_wd;
    rdata_r <= hist_mem[addr_r];
  end

  // ---------------------------------------------------------------- result
  logic [COUNT_BITS-1:0] peak_r, peak_nxt, cnt_inc;
  logic [ITER_W-1:0]     iter_r, iter_nxt;
  logic [BIN_W-1:0]      res_idx;
  logic [CNT_W-1:0]      res_cnt;

  always_comb begin
    cnt_inc    = (rdata_r != COUNT_MAX) ? rdata_r + 1'b1 : rdata_r;
    res_idx    = '0;
    res_cnt    = '0;
    peak_nxt   = peak_r;
    iter_nxt   = iter_r;
    item_wr    = 1'b0;
    item_wdata = '0;
    case (op_r)
      OP_PLOT: begin
        iter_nxt = iter_r + 1'b1;
        if (hit_r) begin
          res_idx    = BIN_W'(addr_r);
          res_cnt    = CNT_W'(cnt_inc);
          item_wr    = 1'b1;
          item_wdata = cnt_inc;
          if (cnt_inc > peak_r) peak_nxt = cnt_inc;
        end
      end
      OP_READ: begin
        res_idx = sel_r;
        if (hit_r) res_cnt = CNT_W'(rdata_r);
      end
      OP_CLEAR: begin
        res_idx = sel_r;
        item_wr = hit_r;
      end
      OP_RESET_STATS: begin
        peak_nxt = '0;
        iter_nxt = '0;
      end
      default: ;
    endcase
  end

  // statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
      iter_r <= '0;
    end else if (out_load) begin
      peak_r <= peak_nxt;
      iter_r <= iter_nxt;
    end
  end

  // output register
  logic              out_ok_r;
  logic [BIN_W-1:0]  out_idx_r;
  logic [CNT_W-1:0]  out_cnt_r, out_max_r;
  logic [ITER_W-1:0] out_iter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ok_r   <= hit_r;
      out_idx_r  <= res_idx;
      out_cnt_r  <= res_cnt;
      out_max_r  <= CNT_W'(peak_nxt);
      out_iter_r <= iter_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = {6'd0, out_iter_r, out_max_r, out_cnt_r, out_idx_r};

  // ---------------------------------------------------------------- checks
  `ASSERT_IMPL(a_no_accept_in_clear, clk, rst_n, state_r == S_CLEAR, !in_tready)
  `ASSERT_NEXT(a_one_item_in_flight, clk, rst_n, in_acc, !in_tready)
  `ASSERT_IMPL(a_addr_in_store, clk, rst_n, state_r == S_READ, 32'(addr_r) < 32'(STORE_DEPTH))
  `ASSERT_NEXT(a_peak_covers_bin, clk, rst_n, out_load && (op_r == OP_PLOT) && hit_r, CNT_W'(peak_r) >= out_cnt_r)

endmodule

### tb/pdh_checker.sv
`timescale 1ns / 1ps
// Result checker for the point density histogram core: shadows the register
// file and the bin store, predicts every result and compares it. Uses pdh_pkg.
module pdh_checker
  import pdh_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [87:0]  in_tdata,   // point_x, point_y, blur_x, blur_y, bin_select
  input  logic [1:0]   in_tuser,   // operation
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [135:0] out_tdata,  // bin_index, bin_count, max_count, iteration_total
  input  logic [0:0]   out_tuser,  // in_range
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  input  logic         cfg_pready,
  output int           fail_count,
  output int           outstanding
);

  typedef struct packed {
    logic        in_range;
    logic [17:0] bin_index;
    logic [31:0] bin_count;
    logic [31:0] max_count;
    logic [47:0] iteration_total;
  } bin_result_t;

  // shadow registers
  logic               rot_en;
  logic signed [15:0] cos_r, sin_r, x_off, y_off;
  logic [15:0]        scale;
  logic [9:0]         width_cfg, height_cfg;

  // shadow bin store and statistics; missing keys read as zero
  int unsigned        bin_store [int];
  logic [31:0]        peak;
  logic [47:0]        iters;
  bin_result_t        pending_results [$];

  // Q.13 coordinate to grid cell, truncated toward zero
  function automatic longint grid_coord(longint q, longint extent);
    longint v;
    v = q * longint'(scale) + (extent <<< 20);
    if (v >= 0) return v >>> 21;
    return -((-v) >>> 21);
  endfunction

  // apply one transaction to the shadow state and return its result
  function automatic bin_result_t apply_op(op_t op, logic [87:0] d);
    bin_result_t r;
    longint px, py, rx, ry, gx, gy, w, h;
    int unsigned cnt;
    int key;
    r = '0;
    case (op)
      OP_PLOT: begin
        px = $signed(d[15:0]);
        py = $signed(d[31:16]);
        w = (width_cfg > MAX_GRID_WIDTH) ? MAX_GRID_WIDTH : width_cfg;
        h = (height_cfg > MAX_GRID_HEIGHT) ? MAX_GRID_HEIGHT : height_cfg;
        if (rot_en) begin
          // floor of the Q1.14 product via arithmetic shift
          rx = (longint'(cos_r) * px + longint'(sin_r) * py) >>> 14;
          ry = (longint'(cos_r) * py - longint'(sin_r) * px) >>> 14;
        end else begin
          rx = px;
          ry = py;
        end
        rx = rx + longint'($signed(d[47:32])) + longint'(x_off);
        ry = ry + longint'($signed(d[63:48])) + longint'(y_off);
        gx = grid_coord(rx, w);
        gy = grid_coord(ry, h);
        iters = iters + 48'd1;
        if (gx >= 0 && gy >= 0 && gx < w && gy < h) begin
          key = int'(gx + w * gy);
          cnt = bin_store.exists(key) ? bin_store[key] : 0;
          if (cnt != 32'hFFFF_FFFF) cnt++;
          bin_store[key] = cnt;
          if (cnt > peak) peak = cnt;
          r.in_range  = 1'b1;
          r.bin_index = BIN_W'(key);
          r.bin_count = cnt;
        end
      end
      OP_READ, OP_CLEAR: begin
        key = int'(d[81:64]);
        r.bin_index = d[81:64];
        if (key < STORE_DEPTH) begin
          r.in_range = 1'b1;
          if (op == OP_CLEAR) bin_store[key] = 0;
          r.bin_count = bin_store.exists(key) ? bin_store[key] : 0;
        end
      end
      OP_RESET_STATS: begin
        peak = '0;
        iters = '0;
        r.in_range = 1'b1;
      end
      default: ;
    endcase
    r.max_count = peak;
    r.iteration_total = iters;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // watch all three ports at the clock edge
  always @(posedge clk) begin
    bin_result_t want, got;
    if (!rst_n) begin
      rot_en = 1'b0;
      cos_r = 16'sd16384;
      sin_r = '0;
      x_off = '0;
      y_off = '0;
      scale = 16'd26214;
      width_cfg = 10'd512;
      height_cfg = 10'd512;
      bin_store.delete();
      pending_results.delete();
      peak = '0;
      iters = '0;
    end else begin
      // register write transaction
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[4:2]))
          REG_ROTATE_ENABLE: rot_en = cfg_pwdata[0];
          REG_COS_ROTATION:  cos_r = cfg_pwdata[15:0];
          REG_SIN_ROTATION:  sin_r = cfg_pwdata[15:0];
          REG_X_OFFSET:      x_off = cfg_pwdata[15:0];
          REG_Y_OFFSET:      y_off = cfg_pwdata[15:0];
          REG_VIEW_SCALE:    scale = cfg_pwdata[15:0];
          REG_GRID_WIDTH:    width_cfg = cfg_pwdata[9:0];
          REG_GRID_HEIGHT:   height_cfg = cfg_pwdata[9:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        pending_results.push_back(apply_op(op_t'(in_tuser), in_tdata));
      // result transaction
      if (out_tvalid && out_tready) begin
        got.in_range        = out_tuser[0];
        got.bin_index       = out_tdata[17:0];
        got.bin_count       = out_tdata[49:18];
        got.max_count       = out_tdata[81:50];
        got.iteration_total = out_tdata[129:82];
        if (pending_results.size() == 0) begin
          $display("%0t ns: unexpected result, bin_index %0d", $time, got.bin_index);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("in_range", 64'(want.in_range), 64'(got.in_range));
          check_field("bin_index", 64'(want.bin_index), 64'(got.bin_index));
          check_field("bin_count", 64'(want.bin_count), 64'(got.bin_count));
          check_field("max_count", 64'(want.max_count), 64'(got.max_count));
          check_field("iteration_total", 64'(want.iteration_total),
                      64'(got.iteration_total));
        end
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

### tb/point_density_histogram_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for point_density_histogram_core: clock, reset, register
// setup, directed and random traffic, verdict. Uses pdh_pkg and pdh_checker.
module point_density_histogram_core_tb;
  import pdh_pkg::*;

  localparam int WATCHDOG_LIMIT = 1200000;
  localparam int CENTER_BIN     = 256 + 512 * 256;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [87:0]  in_tdata;   // point_x, point_y, blur_x, blur_y, bin_select
  logic [1:0]   in_tuser;   // operation
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;  // bin_index, bin_count, max_count, iteration_total
  logic [0:0]   out_tuser;  // in_range
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [4:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  int fail_count;
  int outstanding;
  int stall_cycles = 0;
  bit quiet = 1'b0;

  // current settings, used only to aim the random points and bin selects at the grid
  int cur_w, cur_h, cur_scale, cur_xo, cur_yo;
  logic [31:0] hot_pts [4] = '{default: '0};

  point_density_histogram_core dut (.*);
  pdh_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result side backpressure in random bursts, off in the last phase
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  function automatic logic [87:0] pack_item(int px, int py, int bx, int by, int sel);
    return {6'b0, sel[17:0], by[15:0], bx[15:0], py[15:0], px[15:0]};
  endfunction

  // random coordinate that lands near the grid once the offset is added
  function automatic int near_coord(int span, int off);
    int v;
    v = int'($urandom_range(0, 2 * span)) - span - off;
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v;
  endfunction

  task automatic push_item(op_t op, logic [87:0] data);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // wait until every result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // one register write; unused upper bits carry noise
  task automatic cfg_write(reg_idx_t r, int val);
    logic [31:0] keep;
    case (r)
      REG_ROTATE_ENABLE:               keep = 32'h1;
      REG_GRID_WIDTH, REG_GRID_HEIGHT: keep = 32'h3FF;
      default:                         keep = 32'hFFFF;
    endcase
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= (val & keep) | ($urandom & ~keep);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(bit rot, int c, int s, int xo, int yo, int sc, int w, int h);
    cfg_write(REG_ROTATE_ENABLE, rot);
    cfg_write(REG_COS_ROTATION, c);
    cfg_write(REG_SIN_ROTATION, s);
    cfg_write(REG_X_OFFSET, xo);
    cfg_write(REG_Y_OFFSET, yo);
    cfg_write(REG_VIEW_SCALE, sc);
    cfg_write(REG_GRID_WIDTH, w);
    cfg_write(REG_GRID_HEIGHT, h);
    cur_w = (w[9:0] > MAX_GRID_WIDTH) ? MAX_GRID_WIDTH : w[9:0];
    cur_h = (h[9:0] > MAX_GRID_HEIGHT) ? MAX_GRID_HEIGHT : h[9:0];
    cur_scale = sc & 32'hFFFF;
    cur_xo = $signed(xo[15:0]);
    cur_yo = $signed(yo[15:0]);
  endtask

  // one random transaction, mostly plots aimed at the grid
  task automatic send_random(int idle_pct);
    op_t op;
    int roll, px, py, bx, by, sel, span_x, span_y, cells;
    logic [31:0] hp;
    roll = $urandom_range(0, 99);
    if (roll < 60) op = OP_PLOT;
    else if (roll < 78) op = OP_READ;
    else if (roll < 93) op = OP_CLEAR;
    else op = OP_RESET_STATS;
    px = $urandom;
    py = $urandom;
    bx = $urandom;
    by = $urandom;
    sel = $urandom_range(0, 262143);
    span_x = (cur_scale == 0) ? 32767 : ((cur_w << 20) / cur_scale);
    span_y = (cur_scale == 0) ? 32767 : ((cur_h << 20) / cur_scale);
    if (span_x > 32767) span_x = 32767;
    if (span_y > 32767) span_y = 32767;
    if (op == OP_PLOT) begin
      roll = $urandom_range(0, 9);
      if (roll >= 5) begin
        px = near_coord(span_x, cur_xo);
        py = near_coord(span_y, cur_yo);
      end else if (roll >= 2) begin
        // revisit a recent point so bins build up counts
        hp = hot_pts[$urandom_range(0, 3)];
        px = hp[15:0];
        py = hp[31:16];
      end
      hot_pts[$urandom_range(0, 3)] = {py[15:0], px[15:0]};
      roll = $urandom_range(0, 9);
      if (roll < 7) begin
        bx = 0;
        by = 0;
      end else if (roll < 9) begin
        bx = int'($urandom_range(0, 1024)) - 512;
        by = int'($urandom_range(0, 1024)) - 512;
      end
    end else begin
      cells = cur_w * cur_h;
      if (cells > 0 && $urandom_range(0, 9) < 7) sel = $urandom_range(0, cells - 1);
    end
    if ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    push_item(op, pack_item(px, py, bx, by, sel));
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= OP_PLOT;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values again, written while the store clears
    apply_settings(0, 16384, 0, 0, 0, 26214, 512, 512);

    // directed: center bin, extremes, truncation near zero, read/clear/reset
    push_item(OP_PLOT, pack_item(0, 0, 0, 0, 0));
    push_item(OP_PLOT, pack_item(0, 0, 0, 0, 262143));
    push_item(OP_PLOT, pack_item(32767, 32767, 0, 0, 0));
    push_item(OP_PLOT, pack_item(-32768, -32768, 0, 0, 0));
    // column just below zero truncates onto column 0
    push_item(OP_PLOT, pack_item(-20521, 0, 0, 0, 0));
    // row past -1 falls off the grid
    push_item(OP_PLOT, pack_item(0, -20600, 0, 0, 0));
    push_item(OP_PLOT, pack_item(0, 0, 32767, -32768, 0));
    push_item(OP_PLOT, pack_item(-32768, -32768, 32767, 32767, 0));
    push_item(OP_PLOT, pack_item(100, -100, -100, 100, 0));
    push_item(OP_READ, pack_item(0, 0, 0, 0, CENTER_BIN));
    push_item(OP_READ, pack_item(0, 0, 0, 0, 0));
    push_item(OP_READ, pack_item(0, 0, 0, 0, 262143));
    push_item(OP_CLEAR, pack_item(0, 0, 0, 0, CENTER_BIN));
    push_item(OP_READ, pack_item(0, 0, 0, 0, CENTER_BIN));
    // peak stays after a clear
    push_item(OP_PLOT, pack_item(0, 0, 0, 0, 0));
    push_item(OP_RESET_STATS, pack_item(0, 0, 0, 0, 0));
    push_item(OP_PLOT, pack_item(0, 0, 0, 0, 0));
    push_item(OP_CLEAR, pack_item(-1, -1, -1, -1, 262143));
    push_item(OP_READ, pack_item(-1, -1, -1, -1, 5));
    push_item(OP_RESET_STATS, pack_item(-1, -1, -1, -1, 262143));

    // random phases, each under its own settings
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: apply_settings(0, 16384, 0, 0, 0, 26214, 4, 4);
        1: apply_settings(1, 0, 16384, 100, -50, 65535, 16, 8);
        // zero height and zero scale: nothing lands; width above the maximum
        2: apply_settings(1, -16384, 16384, 0, 0, 0, 1023, 0);
        3: apply_settings(1, $urandom, $urandom, 32767, -32768, $urandom_range(1, 65535), 1, 1);
        4: apply_settings(0, 16384, 0, 0, 0, 26214, 512, 512);
        5: apply_settings(1, int'($urandom_range(0, 32768)) - 16384,
                          int'($urandom_range(0, 32768)) - 16384,
                          int'($urandom_range(0, 4096)) - 2048,
                          int'($urandom_range(0, 4096)) - 2048,
                          $urandom_range(64, 4096), $urandom_range(1, 40), $urandom_range(1, 40));
        6: apply_settings(1, 16384, -16384, -4096, 4096, 6553, 1, 512);
        default: apply_settings(0, 16384, 0, -8192, 8192, 26214, 8, 8);
      endcase
      quiet = (ph == 7);
      repeat ((ph == 2) ? 80 : ((ph == 7) ? 160 : 115))
        send_random((ph == 4 || ph == 7) ? 0 : 30);
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
